// ===== hw/rtl/qac_pkg.sv =====
// ----------------------------------------------------------------------------
// qac_pkg
// Shared types, codes and character tables of the query argument checker.
// ----------------------------------------------------------------------------
`default_nettype none

package qac_pkg;

    localparam int QAC_MAX_QUERY_LEN = 256;

    // Error codes reported in the result beat
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_ARG_START    = 4'd1;
    localparam logic [3:0] ERR_KEY          = 4'd2;
    localparam logic [3:0] ERR_NON_ASCII    = 4'd3;
    localparam logic [3:0] ERR_NO_EQ        = 4'd4;
    localparam logic [3:0] ERR_TOO_LONG     = 4'd5;
    localparam logic [3:0] ERR_NON_GRAPHIC  = 4'd6;
    localparam logic [3:0] ERR_REPEAT       = 4'd7;
    localparam logic [3:0] ERR_ALGO_FIRST   = 4'd8;
    localparam logic [3:0] ERR_ALGO_CHAR    = 4'd9;
    localparam logic [3:0] ERR_BRR_HI       = 4'd10;
    localparam logic [3:0] ERR_BRR_LO       = 4'd11;
    localparam logic [3:0] ERR_BRR_SHORT    = 4'd12;
    localparam logic [3:0] ERR_FNP_EMPTY    = 4'd13;
    localparam logic [3:0] ERR_DANGLING_AMP = 4'd14;
    localparam logic [3:0] ERR_OVERLONG     = 4'd15;

    // Argument codes
    localparam logic [1:0] ARG_NONE = 2'd0;
    localparam logic [1:0] ARG_ALGO = 2'd1;
    localparam logic [1:0] ARG_BRR  = 2'd2;
    localparam logic [1:0] ARG_FNP  = 2'd3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_EQ  = 8'h3d;

    localparam int TDATA_W = 48;

    // Result fields; last member sits in the lowest bits
    typedef struct packed {
        logic [5:0] prefix_len;
        logic [7:0] prefix_start;
        logic       prefix_seen;
        logic [7:0] request_mask;
        logic       mask_seen;
        logic [3:0] algorithm_len;
        logic [7:0] algorithm_start;
        logic       algorithm_seen;
        logic [1:0] error_arg;
        logic [3:0] error_code;
    } qac_result_t;

    // Key text: "algo", "brr", "fnp"
    function automatic logic [7:0] key_char(input logic [1:0] arg, input logic [1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (arg)
            ARG_ALGO: begin
                case (idx)
                    2'd0: c = "a";
                    2'd1: c = "l";
                    2'd2: c = "g";
                    default: c = "o";
                endcase
            end
            ARG_BRR: begin
                case (idx)
                    2'd0: c = "b";
                    2'd1: c = "r";
                    2'd2: c = "r";
                    default: c = 8'h00;
                endcase
            end
            ARG_FNP: begin
                case (idx)
                    2'd0: c = "f";
                    2'd1: c = "n";
                    2'd2: c = "p";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] key_len(input logic [1:0] arg);
        logic [2:0] n;
        case (arg)
            ARG_ALGO: n = 3'd4;
            ARG_BRR:  n = 3'd3;
            ARG_FNP:  n = 3'd3;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] val_max(input logic [1:0] arg);
        logic [5:0] n;
        case (arg)
            ARG_ALGO: n = 6'd8;
            ARG_BRR:  n = 6'd2;
            ARG_FNP:  n = 6'd32;
            default:  n = 6'd0;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] arg_bit(input logic [1:0] arg);
        logic [2:0] b;
        case (arg)
            ARG_ALGO: b = 3'b001;
            ARG_BRR:  b = 3'b010;
            ARG_FNP:  b = 3'b100;
            default:  b = 3'b000;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qac_parser.sv =====
// ----------------------------------------------------------------------------
// qac_parser
// Per-byte parse state and its registered update; builds the result on the
// terminating byte and returns to the query-start state.
// ----------------------------------------------------------------------------
`default_nettype none

module qac_parser #(
    parameter int MAX_QUERY_LEN = qac_pkg::QAC_MAX_QUERY_LEN
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic [7:0]         ch,
    output qac_pkg::qac_result_t    result
);
    import qac_pkg::*;

    localparam int PosW = $clog2(MAX_QUERY_LEN + 1);
    localparam logic [PosW-1:0] MaxPos = PosW'(MAX_QUERY_LEN);

    typedef enum logic [2:0] {
        PH_START,
        PH_AMP,
        PH_KEY,
        PH_EQ,
        PH_VAL
    } phase_t;

    logic [PosW-1:0] pos_reg, pos_next;
    phase_t          phase_reg, phase_next;
    logic [1:0]      arg_reg, arg_next;
    logic [2:0]      kidx_reg, kidx_next;
    logic [5:0]      vcnt_reg, vcnt_next;
    logic [3:0]      ferr_reg, ferr_next;
    logic [1:0]      fown_reg, fown_next;
    logic [3:0]      pend_reg, pend_next;
    logic [2:0]      seen_reg, seen_next;
    logic [7:0]      astart_reg, astart_next;
    logic [3:0]      alen_reg, alen_next;
    logic [7:0]      mask_reg, mask_next;
    logic [7:0]      pstart_reg, pstart_next;
    logic [5:0]      plen_reg, plen_next;

    logic [PosW+7:0] pos_wide;
    logic [5:0]      vcnt_inc;
    logic [2:0]      cur_bit;
    logic            is_lower, is_digit, is_lhex;
    logic [3:0]      nib;
    logic [3:0]      close_code;
    logic            do_close;

    assign pos_wide = {8'h00, pos_reg} + (PosW+8)'(1);
    assign vcnt_inc = (vcnt_reg < 6'd63) ? vcnt_reg + 6'd1 : vcnt_reg;
    assign cur_bit  = arg_bit(arg_reg);
    assign is_lower = ch inside {["a":"z"]};
    assign is_digit = ch inside {["0":"9"]};
    assign is_lhex  = is_digit || (ch inside {["a":"f"]});
    assign nib      = is_digit ? ch[3:0] : ch[3:0] + 4'd9;

    // Verdict of closing the current value
    always_comb begin
        if (arg_reg == ARG_NONE) begin
            close_code = ERR_NONE;
        end else if ((seen_reg & cur_bit) != 3'b000) begin
            close_code = ERR_REPEAT;
        end else if (pend_reg != ERR_NONE) begin
            close_code = pend_reg;
        end else if (arg_reg == ARG_ALGO && vcnt_reg == 6'd0) begin
            close_code = ERR_ALGO_FIRST;
        end else if (arg_reg == ARG_BRR && vcnt_reg < 6'd2) begin
            close_code = ERR_BRR_SHORT;
        end else if (arg_reg == ARG_FNP && vcnt_reg == 6'd0) begin
            close_code = ERR_FNP_EMPTY;
        end else begin
            close_code = ERR_NONE;
        end
    end

    always_comb begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        arg_next    = arg_reg;
        kidx_next   = kidx_reg;
        vcnt_next   = vcnt_reg;
        ferr_next   = ferr_reg;
        fown_next   = fown_reg;
        pend_next   = pend_reg;
        seen_next   = seen_reg;
        astart_next = astart_reg;
        alen_next   = alen_reg;
        mask_next   = mask_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        do_close    = 1'b0;
        result      = '0;

        if (step_en && ch != CH_NUL) begin
            if (ferr_reg == ERR_NONE) begin
                if (pos_reg >= MaxPos) begin
                    ferr_next = ERR_OVERLONG;
                    fown_next = ARG_NONE;
                end else begin
                    case (phase_reg)
                        PH_START, PH_AMP: begin
                            if (ch == "a" || ch == "b" || ch == "f") begin
                                arg_next   = (ch == "a") ? ARG_ALGO :
                                             (ch == "b") ? ARG_BRR : ARG_FNP;
                                kidx_next  = 3'd1;
                                vcnt_next  = 6'd0;
                                pend_next  = ERR_NONE;
                                phase_next = PH_KEY;
                            end else begin
                                ferr_next = ERR_ARG_START;
                                fown_next = ARG_NONE;
                            end
                        end
                        PH_KEY: begin
                            if (ch[7]) begin
                                ferr_next = ERR_NON_ASCII;
                                fown_next = arg_reg;
                            end else if (kidx_reg >= key_len(arg_reg) ||
                                         ch != key_char(arg_reg, kidx_reg[1:0])) begin
                                ferr_next = ERR_KEY;
                                fown_next = arg_reg;
                            end else begin
                                kidx_next = kidx_reg + 3'd1;
                                if (kidx_reg + 3'd1 >= key_len(arg_reg)) begin
                                    phase_next = PH_EQ;
                                end
                            end
                        end
                        PH_EQ: begin
                            if (ch != CH_EQ) begin
                                ferr_next = ERR_NO_EQ;
                                fown_next = arg_reg;
                            end else begin
                                if ((seen_reg & cur_bit) == 3'b000) begin
                                    if (arg_reg == ARG_ALGO) begin
                                        astart_next = pos_wide[7:0];
                                    end else if (arg_reg == ARG_FNP) begin
                                        pstart_next = pos_wide[7:0];
                                    end
                                end
                                phase_next = PH_VAL;
                            end
                        end
                        default: begin
                            if (ch == CH_AMP) begin
                                do_close   = 1'b1;
                                phase_next = PH_AMP;
                            end else begin
                                vcnt_next = vcnt_inc;
                                if (vcnt_inc > val_max(arg_reg)) begin
                                    ferr_next = ERR_TOO_LONG;
                                    fown_next = arg_reg;
                                end else if (ch[7]) begin
                                    ferr_next = ERR_NON_ASCII;
                                    fown_next = arg_reg;
                                end else if (ch < 8'h21 || ch > 8'h7e) begin
                                    ferr_next = ERR_NON_GRAPHIC;
                                    fown_next = arg_reg;
                                end else if (arg_reg == ARG_ALGO) begin
                                    if (pend_reg == ERR_NONE) begin
                                        if (vcnt_inc == 6'd1 && !is_lower) begin
                                            pend_next = ERR_ALGO_FIRST;
                                        end else if (!is_lower && !is_digit) begin
                                            pend_next = ERR_ALGO_CHAR;
                                        end
                                    end
                                end else if (arg_reg == ARG_BRR) begin
                                    if (!is_lhex) begin
                                        if (pend_reg == ERR_NONE) begin
                                            pend_next = (vcnt_inc == 6'd1) ? ERR_BRR_HI
                                                                           : ERR_BRR_LO;
                                        end
                                    end else if (!seen_reg[1]) begin
                                        mask_next = {mask_reg[3:0], nib};
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            if (pos_reg < MaxPos) begin
                pos_next = pos_reg + PosW'(1);
            end
        end else if (step_en) begin
            // Terminator: close what is open
            if (ferr_reg == ERR_NONE) begin
                case (phase_reg)
                    PH_VAL: do_close = 1'b1;
                    PH_KEY: begin
                        ferr_next = ERR_KEY;
                        fown_next = arg_reg;
                    end
                    PH_EQ: begin
                        ferr_next = ERR_NO_EQ;
                        fown_next = arg_reg;
                    end
                    PH_AMP: begin
                        ferr_next = ERR_DANGLING_AMP;
                        fown_next = ARG_NONE;
                    end
                    default: ;
                endcase
            end
        end

        if (do_close) begin
            if (close_code != ERR_NONE) begin
                ferr_next = close_code;
                fown_next = arg_reg;
            end else if (arg_reg != ARG_NONE) begin
                seen_next = seen_reg | cur_bit;
                if (arg_reg == ARG_ALGO) begin
                    alen_next = vcnt_reg[3:0];
                end else if (arg_reg == ARG_FNP) begin
                    plen_next = vcnt_reg;
                end
            end
        end

        if (step_en && ch == CH_NUL) begin
            if (ferr_next != ERR_NONE) begin
                result.error_code = ferr_next;
                result.error_arg  = fown_next;
            end else begin
                if (seen_next[0]) begin
                    result.algorithm_seen  = 1'b1;
                    result.algorithm_start = astart_next;
                    result.algorithm_len   = alen_next;
                end
                if (seen_next[1]) begin
                    result.mask_seen    = 1'b1;
                    result.request_mask = mask_next;
                end
                if (seen_next[2]) begin
                    result.prefix_seen  = 1'b1;
                    result.prefix_start = pstart_next;
                    result.prefix_len   = plen_next;
                end
            end
            // Back to query start for the next query
            pos_next    = '0;
            phase_next  = PH_START;
            arg_next    = ARG_NONE;
            kidx_next   = '0;
            vcnt_next   = '0;
            ferr_next   = ERR_NONE;
            fown_next   = ARG_NONE;
            pend_next   = ERR_NONE;
            seen_next   = '0;
            astart_next = '0;
            alen_next   = '0;
            mask_next   = '0;
            pstart_next = '0;
            plen_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            phase_reg  <= PH_START;
            arg_reg    <= ARG_NONE;
            kidx_reg   <= '0;
            vcnt_reg   <= '0;
            ferr_reg   <= ERR_NONE;
            fown_reg   <= ARG_NONE;
            pend_reg   <= ERR_NONE;
            seen_reg   <= '0;
            astart_reg <= '0;
            alen_reg   <= '0;
            mask_reg   <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            arg_reg    <= arg_next;
            kidx_reg   <= kidx_next;
            vcnt_reg   <= vcnt_next;
            ferr_reg   <= ferr_next;
            fown_reg   <= fown_next;
            pend_reg   <= pend_next;
            seen_reg   <= seen_next;
            astart_reg <= astart_next;
            alen_reg   <= alen_next;
            mask_reg   <= mask_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/query_argument_checker_core.sv =====
// ----------------------------------------------------------------------------
// query_argument_checker_core
// Checks a zero-terminated query string of algo/brr/fnp arguments, one byte
// per beat, and emits one result beat per query.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Bits of tdata                | Beat
//  --------+-----+------------------------------+-------------------------------
//  s_      | in  | ch [7:0]                     | one query byte, 0 ends query
//  m_      | out | result fields [42:0], pad 0  | one beat per terminator byte
//
//  Flow: one byte per cycle unless a held result stalls the pipe; a
//  terminator is registered at the input, then parsed into the result register.
//  The parse state is a handful of small registers updated once per byte;
//  that update is the only path between input and result registers.
//  Reset: synchronous, active low; clears the parser and both valid flags.
//  No clearing pass, so the block accepts beats right after reset.
//  Stalls: with a result held and m_tready low, the whole pipe holds and
//  s_tready drops; otherwise s_tready stays high.
//
`default_nettype none

module query_argument_checker_core #(
    parameter int MAX_QUERY_LEN = qac_pkg::QAC_MAX_QUERY_LEN
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // s_tdata: ch[7:0]
    input  wire logic [7:0]                  s_tdata,
    input  wire logic                        s_tvalid,
    output wire logic                        s_tready,
    // m_tdata: error_code[3:0], error_arg[5:4], algorithm_seen[6],
    //   algorithm_start[14:7], algorithm_len[18:15], mask_seen[19],
    //   request_mask[27:20], prefix_seen[28], prefix_start[36:29],
    //   prefix_len[42:37], zero pad[47:43]
    output wire logic [qac_pkg::TDATA_W-1:0] m_tdata,
    output wire logic                        m_tvalid,
    input  wire logic                        m_tready
);
    import qac_pkg::*;

    localparam int ResW = $bits(qac_result_t);

    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        m_valid_reg, m_valid_next;
    qac_result_t m_data_reg;
    qac_result_t result;
    logic        advance;
    logic        step_en;
    logic        is_term;

    // Advance the pipe unless a result is stuck at the output
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign step_en  = advance && in_valid_reg;
    assign is_term  = in_valid_reg && in_ch_reg == CH_NUL;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(TDATA_W - ResW)'(0), m_data_reg};

    qac_parser #(
        .MAX_QUERY_LEN(MAX_QUERY_LEN)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .ch      (in_ch_reg),
        .result  (result)
    );

    // A result beat is loaded only when the terminator leaves the input register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = is_term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                in_valid_reg <= s_tvalid;
            end
        end
        // Payload: hold while stalled
        if (advance) begin
            in_ch_reg <= s_tdata;
            if (is_term) begin
                m_data_reg <= result;
            end
        end
    end

    // An error result carries nothing beyond code and argument
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] != ERR_NONE |-> m_tdata[47:6] == '0)
        else $error("error result with payload fields set");

    // A faulting argument is named only alongside an error code
    a_arg_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5:4] != ARG_NONE |-> m_tdata[3:0] != ERR_NONE)
        else $error("error_arg set without error_code");

    // A terminator moving out of the input register yields a result beat
    a_term_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_term |=> m_tvalid)
        else $error("terminator beat produced no result");

    // Reported lengths stay within their value limits
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[18:15] != 4'd0 && m_tdata[18:15] <= 4'd8)
        else $error("algorithm_len out of range");

    a_plen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28] |-> m_tdata[42:37] != 6'd0 && m_tdata[42:37] <= 6'd32)
        else $error("prefix_len out of range");

endmodule

`default_nettype wire

// ===== tb/sv/query_argument_checker_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// query_argument_checker_core_tb
// Streams zero-terminated query strings into the checker, one byte per beat.
// A parser model follows every accepted byte and queues the result that each
// terminator should produce. Every result beat is then checked field by field
// against the oldest queued result. Most queries are well formed, with random
// content and random argument order; the rest are mutated or plain noise.
// The sender pauses between bursts and the receiver stalls in shifting modes.
// ----------------------------------------------------------------------------

import qac_pkg::*;

typedef enum logic [2:0] {
    SCAN_START,
    SCAN_AFTER_AMP,
    SCAN_KEY,
    SCAN_EQ,
    SCAN_VALUE
} scan_phase_t;

class qac_query_tracker;
    qac_result_t expected_results[$];
    int unsigned mismatches;
    int unsigned results_seen;

    logic [8:0]  position;
    scan_phase_t phase;
    logic [1:0]  arg;
    logic [2:0]  key_pos;
    logic [5:0]  value_len;
    logic [3:0]  first_err;
    logic [1:0]  err_arg;
    logic [3:0]  form_err;
    logic [2:0]  seen;
    logic [7:0]  algo_start;
    logic [3:0]  algo_len;
    logic [7:0]  mask;
    logic [7:0]  prefix_start;
    logic [5:0]  prefix_len;
    string       key_word[4];

    function new();
        key_word = '{"", "algo", "brr", "fnp"};
        mismatches = 0;
        results_seen = 0;
        restart();
    endfunction

    function void restart();
        position = '0;
        phase = SCAN_START;
        arg = ARG_NONE;
        key_pos = '0;
        value_len = '0;
        first_err = ERR_NONE;
        err_arg = ARG_NONE;
        form_err = ERR_NONE;
        seen = '0;
        algo_start = '0;
        algo_len = '0;
        mask = '0;
        prefix_start = '0;
        prefix_len = '0;
    endfunction

    function void latch_error(logic [3:0] code, logic [1:0] who);
        if (first_err == ERR_NONE) begin
            first_err = code;
            err_arg = who;
        end
    endfunction

    function logic [2:0] flag_of(logic [1:0] a);
        case (a)
            ARG_ALGO: return 3'b001;
            ARG_BRR:  return 3'b010;
            ARG_FNP:  return 3'b100;
            default:  return 3'b000;
        endcase
    endfunction

    function int value_limit(logic [1:0] a);
        case (a)
            ARG_ALGO: return 8;
            ARG_BRR:  return 2;
            ARG_FNP:  return 32;
            default:  return 0;
        endcase
    endfunction

    // Value ends on '&' or on the terminator: repeat beats any form error
    function void close_value();
        if (arg == ARG_NONE)
            return;
        if ((seen & flag_of(arg)) != 0)
            latch_error(ERR_REPEAT, arg);
        else if (form_err != ERR_NONE)
            latch_error(form_err, arg);
        else if (arg == ARG_ALGO && value_len == 0)
            latch_error(ERR_ALGO_FIRST, arg);
        else if (arg == ARG_BRR && value_len < 2)
            latch_error(ERR_BRR_SHORT, arg);
        else if (arg == ARG_FNP && value_len == 0)
            latch_error(ERR_FNP_EMPTY, arg);
        else begin
            seen = seen | flag_of(arg);
            if (arg == ARG_ALGO)
                algo_len = value_len[3:0];
            else if (arg == ARG_FNP)
                prefix_len = value_len;
        end
    endfunction

    function void value_byte(logic [7:0] c);
        bit lower;
        bit digit;
        bit lhex;
        logic [3:0] nib;
        lower = (c >= "a" && c <= "z");
        digit = (c >= "0" && c <= "9");
        lhex = digit || (c >= "a" && c <= "f");
        if (value_len < 63)
            value_len++;
        // length, non-ascii and non-graphic win over form errors
        if (value_len > value_limit(arg)) begin
            latch_error(ERR_TOO_LONG, arg);
            return;
        end
        if (c >= 8'h80) begin
            latch_error(ERR_NON_ASCII, arg);
            return;
        end
        if (c < 8'h21 || c > 8'h7e) begin
            latch_error(ERR_NON_GRAPHIC, arg);
            return;
        end
        if (arg == ARG_ALGO) begin
            if (form_err == ERR_NONE) begin
                if (value_len == 1 && !lower)
                    form_err = ERR_ALGO_FIRST;
                else if (!lower && !digit)
                    form_err = ERR_ALGO_CHAR;
            end
        end else if (arg == ARG_BRR) begin
            if (!lhex) begin
                if (form_err == ERR_NONE)
                    form_err = (value_len == 1) ? ERR_BRR_HI : ERR_BRR_LO;
            end else if (seen[1] == 1'b0) begin
                nib = digit ? 4'(c - "0") : 4'(c - "a" + 8'd10);
                mask = {mask[3:0], nib};
            end
        end
    endfunction

    function void scan_byte(logic [7:0] c);
        string w;
        w = key_word[arg];
        case (phase)
            SCAN_START, SCAN_AFTER_AMP: begin
                if (c == "a")
                    arg = ARG_ALGO;
                else if (c == "b")
                    arg = ARG_BRR;
                else if (c == "f")
                    arg = ARG_FNP;
                else begin
                    latch_error(ERR_ARG_START, ARG_NONE);
                    return;
                end
                key_pos = 3'd1;
                value_len = '0;
                form_err = ERR_NONE;
                phase = SCAN_KEY;
            end
            SCAN_KEY: begin
                if (c >= 8'h80) begin
                    latch_error(ERR_NON_ASCII, arg);
                    return;
                end
                if (key_pos >= w.len() || c != w.getc(key_pos)) begin
                    latch_error(ERR_KEY, arg);
                    return;
                end
                key_pos++;
                if (key_pos >= w.len())
                    phase = SCAN_EQ;
            end
            SCAN_EQ: begin
                if (c != CH_EQ) begin
                    latch_error(ERR_NO_EQ, arg);
                    return;
                end
                if ((seen & flag_of(arg)) == 0) begin
                    if (arg == ARG_ALGO)
                        algo_start = 8'(position + 9'd1);
                    else if (arg == ARG_FNP)
                        prefix_start = 8'(position + 9'd1);
                end
                phase = SCAN_VALUE;
            end
            default: begin
                if (c == CH_AMP) begin
                    close_value();
                    phase = SCAN_AFTER_AMP;
                end else begin
                    value_byte(c);
                end
            end
        endcase
    endfunction

    // Note one accepted query byte; a terminator queues its result
    function void note_byte(logic [7:0] c);
        qac_result_t r;
        if (c != CH_NUL) begin
            if (first_err == ERR_NONE) begin
                if (position >= QAC_MAX_QUERY_LEN)
                    latch_error(ERR_OVERLONG, ARG_NONE);
                else
                    scan_byte(c);
            end
            if (position < QAC_MAX_QUERY_LEN)
                position++;
            return;
        end
        if (first_err == ERR_NONE) begin
            case (phase)
                SCAN_VALUE:     close_value();
                SCAN_KEY:       latch_error(ERR_KEY, arg);
                SCAN_EQ:        latch_error(ERR_NO_EQ, arg);
                SCAN_AFTER_AMP: latch_error(ERR_DANGLING_AMP, ARG_NONE);
                default:        ;
            endcase
        end
        r = '0;
        if (first_err != ERR_NONE) begin
            r.error_code = first_err;
            r.error_arg = err_arg;
        end else begin
            if (seen[0]) begin
                r.algorithm_seen = 1'b1;
                r.algorithm_start = algo_start;
                r.algorithm_len = algo_len;
            end
            if (seen[1]) begin
                r.mask_seen = 1'b1;
                r.request_mask = mask;
            end
            if (seen[2]) begin
                r.prefix_seen = 1'b1;
                r.prefix_start = prefix_start;
                r.prefix_len = prefix_len;
            end
        end
        expected_results.push_back(r);
        restart();
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got,
                                inout bit bad);
        if (got !== want) begin
            if (mismatches < 10) begin
                if (!bad)
                    $display("result %0d mismatch:", results_seen);
                $display("    %s expected %0h got %0h", name, want, got);
            end
            bad = 1'b1;
        end
    endfunction

    function void check_result(logic [TDATA_W-1:0] data);
        qac_result_t got;
        qac_result_t want;
        bit bad;
        got = data[$bits(qac_result_t)-1:0];
        results_seen++;
        if (expected_results.size() == 0) begin
            if (mismatches < 10)
                $display("result %0d arrived with no query outstanding: %h",
                         results_seen, data);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        bad = 1'b0;
        compare_field("error_code", 8'(want.error_code), 8'(got.error_code), bad);
        compare_field("error_arg", 8'(want.error_arg), 8'(got.error_arg), bad);
        compare_field("algorithm_seen", 8'(want.algorithm_seen),
                      8'(got.algorithm_seen), bad);
        compare_field("algorithm_start", want.algorithm_start, got.algorithm_start, bad);
        compare_field("algorithm_len", 8'(want.algorithm_len), 8'(got.algorithm_len), bad);
        compare_field("mask_seen", 8'(want.mask_seen), 8'(got.mask_seen), bad);
        compare_field("request_mask", want.request_mask, got.request_mask, bad);
        compare_field("prefix_seen", 8'(want.prefix_seen), 8'(got.prefix_seen), bad);
        compare_field("prefix_start", want.prefix_start, got.prefix_start, bad);
        compare_field("prefix_len", 8'(want.prefix_len), 8'(got.prefix_len), bad);
        compare_field("pad", 8'h00, 8'(data[TDATA_W-1:$bits(qac_result_t)]), bad);
        if (bad)
            mismatches++;
    endfunction
endclass

module query_argument_checker_core_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 1500;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    // s_tdata: ch[7:0]
    logic [7:0]         s_tdata = 8'h00;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // m_tdata: error_code, error_arg, algorithm fields, mask fields,
    //   prefix fields, zero pad (lowest bits first)
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    qac_query_tracker tracker = new();

    // Bytes of the query being built; the terminator is added on send
    logic [7:0]  query_bytes[$];
    int unsigned bytes_sent = 0;
    int          burst_left = 0;
    int unsigned cycle_count = 0;

    query_argument_checker_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // Watchdog: end the run if the pipe never drains
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("query_argument_checker_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check every accepted beat, then pick the next ready value.
    // Modes switch at random intervals between always ready, light and
    // heavy random stalls, and a square wave from bit 3 of the cycle count.
    // ------------------------------------------------------------------------
    int ready_mode = 0;
    int ready_left = 0;

    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            tracker.check_result(m_tdata);
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(50, 300);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 7);
            2:       m_tready <= ($urandom_range(0, 9) < 2);
            default: m_tready <= cycle_count[3];
        endcase
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Hand one byte over; bursts of random length, idle gaps between them
    task automatic push_byte(input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                              : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_byte(ch);
        bytes_sent++;
        burst_left--;
    endtask

    // Send the built query plus its terminator, then drop the buffer
    task automatic send_query();
        foreach (query_bytes[i])
            push_byte(query_bytes[i]);
        push_byte(CH_NUL);
        query_bytes.delete();
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            query_bytes.push_back(s.getc(i));
    endfunction

    function automatic logic [7:0] pick_lower();
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_lhex();
        int n;
        n = $urandom_range(0, 15);
        return (n < 10) ? 8'("0" + n) : 8'("a" + n - 10);
    endfunction

    // Graphic, but never '&' so that the value stays in one piece
    function automatic logic [7:0] pick_graphic();
        logic [7:0] c;
        c = 8'($urandom_range(8'h21, 8'h7e));
        return (c == CH_AMP) ? 8'h25 : c;
    endfunction

    // Control byte, space, DEL or high byte; never zero
    function automatic logic [7:0] pick_odd();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h80, 8'hff));
            1:       return 8'h7f;
            2:       return 8'h20;
            default: return 8'($urandom_range(8'h01, 8'h1f));
        endcase
    endfunction

    // Letters and punctuation that break algo or brr but are graphic
    function automatic logic [7:0] pick_bad_form();
        case ($urandom_range(0, 3))
            0:       return 8'("A" + $urandom_range(0, 25));
            1:       return 8'("g" + $urandom_range(0, 19));
            2:       return 8'h2d;
            default: return 8'h5f;
        endcase
    endfunction

    function automatic void put_algo_value();
        int n;
        case ($urandom_range(0, 11))
            0: ;
            1: repeat ($urandom_range(9, 11)) query_bytes.push_back(pick_lower());
            2: begin
                query_bytes.push_back(pick_digit());
                repeat ($urandom_range(0, 3)) query_bytes.push_back(pick_lower());
            end
            3: begin
                query_bytes.push_back(pick_lower());
                query_bytes.push_back(pick_bad_form());
                repeat ($urandom_range(0, 3)) query_bytes.push_back(pick_lower());
            end
            4: begin
                query_bytes.push_back(pick_lower());
                query_bytes.push_back(pick_odd());
            end
            default: begin
                n = $urandom_range(1, 8);
                query_bytes.push_back(pick_lower());
                repeat (n - 1)
                    query_bytes.push_back($urandom_range(0, 2) == 0 ? pick_digit()
                                                                    : pick_lower());
            end
        endcase
    endfunction

    function automatic void put_brr_value();
        case ($urandom_range(0, 12))
            0: ;
            1: query_bytes.push_back(pick_lhex());
            2: repeat (3) query_bytes.push_back(pick_lhex());
            3: begin
                query_bytes.push_back(pick_bad_form());
                query_bytes.push_back(pick_lhex());
            end
            4: begin
                query_bytes.push_back(pick_lhex());
                query_bytes.push_back(pick_bad_form());
            end
            5: begin
                query_bytes.push_back(pick_lhex());
                query_bytes.push_back(pick_odd());
            end
            default: repeat (2) query_bytes.push_back(pick_lhex());
        endcase
    endfunction

    function automatic void put_fnp_value();
        int n;
        case ($urandom_range(0, 11))
            0: ;
            1: repeat ($urandom_range(33, 35)) query_bytes.push_back(pick_graphic());
            2: begin
                repeat ($urandom_range(0, 4)) query_bytes.push_back(pick_graphic());
                query_bytes.push_back(pick_odd());
            end
            default: begin
                n = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 10);
                repeat (n) query_bytes.push_back(pick_graphic());
            end
        endcase
    endfunction

    function automatic void put_argument(logic [1:0] a);
        case (a)
            ARG_ALGO: begin
                put_text("algo=");
                put_algo_value();
            end
            ARG_BRR: begin
                put_text("brr=");
                put_brr_value();
            end
            default: begin
                put_text("fnp=");
                put_fnp_value();
            end
        endcase
    endfunction

    // Mostly well-formed argument lists, some mutated, some noise
    function automatic void build_query();
        logic [1:0] order[3];
        logic [1:0] t;
        int kind;
        int nargs;
        int j;
        kind = $urandom_range(0, 99);
        if (kind < 5)
            return;
        if (kind < 12) begin
            repeat ($urandom_range(1, 12))
                query_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end
        if (kind < 14) begin
            // run past the length limit; the position counter saturates
            put_text("algo=a&x");
            repeat ($urandom_range(250, 270))
                query_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end
        order = '{ARG_ALGO, ARG_BRR, ARG_FNP};
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        nargs = $urandom_range(1, 3);
        for (int i = 0; i < nargs; i++) begin
            if (i > 0)
                query_bytes.push_back(CH_AMP);
            put_argument(order[i]);
        end
        if ($urandom_range(0, 9) == 0) begin
            query_bytes.push_back(CH_AMP);
            put_argument(order[$urandom_range(0, nargs - 1)]);
        end
        if ($urandom_range(0, 99) < 15) begin
            j = $urandom_range(0, query_bytes.size() - 1);
            case ($urandom_range(0, 4))
                0: query_bytes.push_back(CH_AMP);
                1: query_bytes[j] = 8'($urandom_range(1, 255));
                2: query_bytes.insert(j, CH_AMP);
                3: while (query_bytes.size() > j + 1) void'(query_bytes.pop_back());
                default: query_bytes[j] = pick_lower();
            endcase
        end
    endfunction

    // Short queries aimed at extremes, at each error but ERR_OVERLONG and at special cases
    string directed_queries[$] = '{
        "",
        "algo=abcdefgh&brr=ff&fnp=!~",
        "fnp=~!#$%^*()_+-{}[]:;<>?,./|\\~@x&brr=00&algo=z9",
        "brr=9a",
        "x",
        "algo=a&&brr=00",
        "algo=a&",
        "alga=b",
        "algo",
        "algox",
        "a\200go=a",
        "algo=abcdefghi",
        "algo=1a",
        "algo=a-b",
        "algo=",
        "brr=g0",
        "brr=0g",
        "brr=0",
        "fnp=",
        "fnp=a b",
        "fnp=a\377",
        "fnp=!!!!!!!!!!!!!!!!!!!!!!!!!!!!!!!!!",
        "algo=a1&algo=b",
        "brr=0G&brr=12",
        "algo=a&br&r"
    };

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_queries[i]) begin
            put_text(directed_queries[i]);
            send_query();
        end

        while (bytes_sent < RANDOM_BYTES) begin
            build_query();
            send_query();
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for any stray beat
        while (tracker.expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
            $display("query_argument_checker_core verification clean");
        end else begin
            $display("query_argument_checker_core verification failed");
        end
        $finish;
    end

endmodule
